// ===== sv/robot_mode_drive_controller_macros.svh =====
// assertion helpers for the robot mode drive controller
`ifndef ROBOT_MODE_DRIVE_CONTROLLER_MACROS_SVH
`define ROBOT_MODE_DRIVE_CONTROLLER_MACROS_SVH

`ifndef SYNTH
`define RMDC_ASSERT_NOW(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rmdc assertion failed");
`define RMDC_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rmdc assertion failed");
`else
`define RMDC_ASSERT_NOW(label, clk, rst, pre, post)
`define RMDC_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== sv/rmdc_pkg.sv =====
package rmdc_pkg;

  typedef enum logic [1:0] {
    MODE_LINE = 2'd0,
    MODE_OBST = 2'd1,
    MODE_WAVE = 2'd2
  } mode_t;

  localparam logic [2:0] REG_CRUISE     = 3'd0;
  localparam logic [2:0] REG_SHARP_TURN = 3'd1;
  localparam logic [2:0] REG_MID_TURN   = 3'd2;
  localparam logic [2:0] REG_SLOW_TURN  = 3'd3;
  localparam logic [2:0] REG_IMPACTS    = 3'd4;
  localparam logic [2:0] REG_BUMP_HOLD  = 3'd5;
  localparam logic [2:0] REG_RES_HOLD   = 3'd6;

  localparam logic [23:0] COL_GREEN   = 24'h7ED321;
  localparam logic [23:0] COL_BLUE    = 24'h20A6D3;
  localparam logic [23:0] COL_RED     = 24'hD32020;
  localparam logic [23:0] COL_START_A = 24'h5520D3;
  localparam logic [23:0] COL_START_B = 24'h20D3C1;

  localparam logic [1:0] WAVE_IDLE = 2'd0;
  localparam logic [1:0] WAVE_LEFT = 2'd1;
  localparam logic [1:0] WAVE_MID  = 2'd2;

  typedef struct packed {
    logic [7:0]  cruise_speed;
    logic [7:0]  sharp_turn_speed;
    logic [7:0]  mid_turn_speed;
    logic [7:0]  slow_turn_speed;
    logic [3:0]  impacts_to_switch;
    logic [15:0] bump_hold_ticks;
    logic [15:0] result_hold_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [3:0]  impact_count;
    logic        wait_release;
    logic [16:0] hold_count;
    logic [1:0]  wave_progress;
  } ctl_t;

  typedef struct packed {
    logic signed [8:0] drive_port1;
    logic signed [8:0] drive_port9;
    logic signed [8:0] drive_port2;
    logic signed [8:0] drive_port10;
    logic [23:0]       led_a_rgb;
    logic [23:0]       led_b_rgb;
  } disp_t;

  typedef struct packed {
    logic line_left_dark;
    logic line_right_dark;
    logic bumper_pressed;
    logic barrier_left;
    logic barrier_middle;
    logic barrier_right;
  } sense_t;

endpackage

// ===== sv/robot_mode_drive_controller.sv =====
// channel      | dir | words           | payload
// s_axis       | in  | one sensor tick | 6 sensor bits in tdata
// m_axis       | out | one per tick     | 4 drives, 2 colors, mode, holding
// apb          | in  | register access | 7 registers at 4*i
//
// one tick per clock cycle unless the result is stalled, result registered in the
// cycle after the sample is taken, by a single pass of next state logic between
// the state registers and the result register
// rst (synchronous) restores register defaults, line mode and start colors
// a stalled result holds in the result register; a new sample is taken
// whenever the result register is empty or being emptied
module robot_mode_drive_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // line_left_dark, line_right_dark, bumper_pressed, barrier_left,
  // barrier_middle, barrier_right, zero fill
  input  logic [7:0]  s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // drive_port1, drive_port9, drive_port2, drive_port10, led_a_rgb,
  // led_b_rgb, current_mode, holding, zero fill
  output logic [87:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rmdc_pkg::*;

  `include "robot_mode_drive_controller_macros.svh"

  cfg_t   cfg;
  ctl_t   ctl, ctl_next;
  disp_t  disp, disp_next;
  sense_t sense;
  logic   holding_next;
  logic   take, cfg_write;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  assign sense.line_left_dark  = s_axis_tdata[0];
  assign sense.line_right_dark = s_axis_tdata[1];
  assign sense.bumper_pressed  = s_axis_tdata[2];
  assign sense.barrier_left    = s_axis_tdata[3];
  assign sense.barrier_middle  = s_axis_tdata[4];
  assign sense.barrier_right   = s_axis_tdata[5];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  rmdc_step u_step (
    .cfg       (cfg),
    .ctl       (ctl),
    .disp      (disp),
    .sense     (sense),
    .ctl_next  (ctl_next),
    .disp_next (disp_next),
    .holding   (holding_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_speed      <= 8'd102;
      cfg.sharp_turn_speed  <= 8'd127;
      cfg.mid_turn_speed    <= 8'd76;
      cfg.slow_turn_speed   <= 8'd25;
      cfg.impacts_to_switch <= 4'd3;
      cfg.bump_hold_ticks   <= 16'd400;
      cfg.result_hold_ticks <= 16'd2000;
    end else if (cfg_write) begin
      case (reg_index)
        REG_CRUISE:     cfg.cruise_speed      <= pwdata[7:0];
        REG_SHARP_TURN: cfg.sharp_turn_speed  <= pwdata[7:0];
        REG_MID_TURN:   cfg.mid_turn_speed    <= pwdata[7:0];
        REG_SLOW_TURN:  cfg.slow_turn_speed   <= pwdata[7:0];
        REG_IMPACTS:    cfg.impacts_to_switch <= pwdata[3:0];
        REG_BUMP_HOLD:  cfg.bump_hold_ticks   <= pwdata[15:0];
        REG_RES_HOLD:   cfg.result_hold_ticks <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CRUISE:     prdata = {24'd0, cfg.cruise_speed};
      REG_SHARP_TURN: prdata = {24'd0, cfg.sharp_turn_speed};
      REG_MID_TURN:   prdata = {24'd0, cfg.mid_turn_speed};
      REG_SLOW_TURN:  prdata = {24'd0, cfg.slow_turn_speed};
      REG_IMPACTS:    prdata = {28'd0, cfg.impacts_to_switch};
      REG_BUMP_HOLD:  prdata = {16'd0, cfg.bump_hold_ticks};
      REG_RES_HOLD:   prdata = {16'd0, cfg.result_hold_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.mode              <= MODE_LINE;
      ctl.impact_count      <= 4'd0;
      ctl.wait_release      <= 1'b0;
      ctl.hold_count        <= 17'd0;
      ctl.wave_progress     <= WAVE_IDLE;
      disp.drive_port1      <= '0;
      disp.drive_port9      <= '0;
      disp.drive_port2      <= '0;
      disp.drive_port10     <= '0;
      disp.led_a_rgb        <= COL_START_A;
      disp.led_b_rgb        <= COL_START_B;
    end else if (take) begin
      ctl  <= ctl_next;
      disp <= disp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= {1'b0, holding_next, ctl_next.mode,
                       disp_next.led_b_rgb, disp_next.led_a_rgb,
                       disp_next.drive_port10, disp_next.drive_port2,
                       disp_next.drive_port9, disp_next.drive_port1};
    end
  end

  `RMDC_ASSERT_NEXT(a_hold_counts_down, clk, rst,
    take && (ctl.hold_count != 17'd0), ctl.hold_count == $past(ctl.hold_count) - 17'd1)
  `RMDC_ASSERT_NOW(a_wait_only_in_line, clk, rst,
    ctl.wait_release, (ctl.mode == MODE_LINE) && (ctl.hold_count == 17'd0))
  `RMDC_ASSERT_NOW(a_wave_stopped, clk, rst,
    ctl.mode == MODE_WAVE, (disp.drive_port1 == 9'sd0) && (disp.drive_port9 == 9'sd0) &&
    (disp.drive_port2 == 9'sd0) && (disp.drive_port10 == 9'sd0))
  `RMDC_ASSERT_NOW(a_ready_when_empty, clk, rst,
    !m_axis_tvalid, s_axis_tready)

endmodule

// ===== sv/rmdc_step.sv =====
module rmdc_step (
  input  rmdc_pkg::cfg_t   cfg,
  input  rmdc_pkg::ctl_t   ctl,
  input  rmdc_pkg::disp_t  disp,
  input  rmdc_pkg::sense_t sense,
  output rmdc_pkg::ctl_t   ctl_next,
  output rmdc_pkg::disp_t  disp_next,
  output logic             holding
);
  import rmdc_pkg::*;

  logic hold_active, wait_active, run, released, do_switch;
  logic obs_fwd, obs_left, obs_right, obs_stop;
  logic [1:0] wp_a, wp_b;
  logic bad, good;
  logic signed [8:0] cr, sh, md, sl;

  assign cr = $signed({1'b0, cfg.cruise_speed});
  assign sh = $signed({1'b0, cfg.sharp_turn_speed});
  assign md = $signed({1'b0, cfg.mid_turn_speed});
  assign sl = $signed({1'b0, cfg.slow_turn_speed});

  assign hold_active = (ctl.hold_count != 17'd0);
  assign wait_active = !hold_active && ctl.wait_release;
  assign run         = !hold_active && !ctl.wait_release;
  assign released    = wait_active && !sense.bumper_pressed;
  assign do_switch   = released && (ctl.impact_count >= cfg.impacts_to_switch);

  assign obs_fwd   = !sense.barrier_left && !sense.barrier_middle && !sense.barrier_right;
  assign obs_left  = sense.barrier_left && !sense.barrier_right;
  assign obs_right = !sense.barrier_left && sense.barrier_right;
  assign obs_stop  = !sense.barrier_left && sense.barrier_middle && !sense.barrier_right;

  // wave sequence left, middle, right
  assign wp_a = sense.barrier_left ? WAVE_LEFT : ctl.wave_progress;
  assign bad  = sense.barrier_middle && (wp_a == WAVE_IDLE);
  assign wp_b = (sense.barrier_middle && (wp_a == WAVE_LEFT)) ? WAVE_MID : wp_a;
  assign good = sense.barrier_right && (wp_b == WAVE_MID);

  assign holding = !run;

  // next state
  always_comb begin
    ctl_next = ctl;
    if (hold_active) begin
      ctl_next.hold_count = ctl.hold_count - 17'd1;
    end else if (wait_active) begin
      if (released) begin
        ctl_next.wait_release = 1'b0;
        ctl_next.hold_count   = {1'b0, cfg.bump_hold_ticks};
        if (do_switch) begin
          ctl_next.mode = MODE_OBST;
        end
      end
    end else begin
      case (ctl.mode)
        MODE_LINE: begin
          if (sense.bumper_pressed) begin
            if (ctl.impact_count != 4'd15) begin
              ctl_next.impact_count = ctl.impact_count + 4'd1;
            end
            ctl_next.wait_release = 1'b1;
          end
        end
        MODE_OBST: begin
          if (!obs_fwd && !obs_left && !obs_right && obs_stop) begin
            ctl_next.mode = MODE_WAVE;
          end
        end
        MODE_WAVE: begin
          if (good) begin
            ctl_next.hold_count    = {1'b0, cfg.result_hold_ticks};
            ctl_next.wave_progress = WAVE_IDLE;
            ctl_next.mode          = MODE_LINE;
          end else if (bad) begin
            ctl_next.hold_count    = {1'b0, cfg.result_hold_ticks};
            ctl_next.wave_progress = WAVE_IDLE;
          end else begin
            ctl_next.wave_progress = wp_b;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // drives and colors
  always_comb begin
    disp_next = disp;
    if (do_switch) begin
      disp_next.led_a_rgb = COL_START_A;
      disp_next.led_b_rgb = COL_START_B;
    end
    if (run) begin
      case (ctl.mode)
        MODE_LINE: begin
          if (sense.line_left_dark && sense.line_right_dark) begin
            disp_next.drive_port1  = cr;
            disp_next.drive_port9  = cr;
            disp_next.drive_port2  = -cr;
            disp_next.drive_port10 = -cr;
            disp_next.led_a_rgb    = COL_GREEN;
            disp_next.led_b_rgb    = COL_GREEN;
          end else if (sense.line_right_dark) begin
            disp_next.drive_port1  = -sl;
            disp_next.drive_port9  = -sl;
            disp_next.drive_port2  = -sh;
            disp_next.drive_port10 = -sh;
            disp_next.led_b_rgb    = COL_BLUE;
          end else if (sense.line_left_dark) begin
            disp_next.drive_port1  = sh;
            disp_next.drive_port9  = sh;
            disp_next.drive_port2  = sl;
            disp_next.drive_port10 = sl;
            disp_next.led_a_rgb    = COL_BLUE;
          end else begin
            disp_next.drive_port1  = '0;
            disp_next.drive_port9  = '0;
            disp_next.drive_port2  = '0;
            disp_next.drive_port10 = '0;
            disp_next.led_a_rgb    = COL_RED;
            disp_next.led_b_rgb    = COL_RED;
          end
        end
        MODE_OBST: begin
          if (obs_fwd) begin
            disp_next.drive_port1  = cr;
            disp_next.drive_port9  = cr;
            disp_next.drive_port2  = -cr;
            disp_next.drive_port10 = -cr;
            disp_next.led_a_rgb    = COL_GREEN;
            disp_next.led_b_rgb    = COL_GREEN;
          end else if (obs_left) begin
            disp_next.drive_port1  = -sl;
            disp_next.drive_port9  = -sl;
            disp_next.drive_port2  = -md;
            disp_next.drive_port10 = -md;
            disp_next.led_b_rgb    = COL_BLUE;
          end else if (obs_right) begin
            disp_next.drive_port1  = md;
            disp_next.drive_port9  = md;
            disp_next.drive_port2  = sl;
            disp_next.drive_port10 = sl;
            disp_next.led_a_rgb    = COL_BLUE;
          end else if (obs_stop) begin
            disp_next.drive_port1  = '0;
            disp_next.drive_port9  = '0;
            disp_next.drive_port2  = '0;
            disp_next.drive_port10 = '0;
            disp_next.led_a_rgb    = COL_RED;
            disp_next.led_b_rgb    = COL_RED;
          end
        end
        MODE_WAVE: begin
          if (good) begin
            disp_next.led_a_rgb = COL_GREEN;
            disp_next.led_b_rgb = COL_GREEN;
          end else if (bad) begin
            disp_next.led_a_rgb = COL_RED;
            disp_next.led_b_rgb = COL_RED;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rmdc_pkg::*;

  // result word as it sits in m_axis_tdata, drive_port1 in the lowest bits
  typedef struct packed {
    logic              holding;
    mode_t             mode;
    logic [23:0]       led_b;
    logic [23:0]       led_a;
    logic signed [8:0] p10;
    logic signed [8:0] p2;
    logic signed [8:0] p9;
    logic signed [8:0] p1;
  } drive_word_t;

  typedef struct {
    bit          is_write;
    logic [2:0]  sel;
    logic [15:0] value;
    logic [5:0]  sense;
    bit          typed;
    drive_word_t want;
  } plan_row_t;

  // sensor bits in s_axis_tdata order
  localparam logic [5:0] S_LL   = 6'b000001;
  localparam logic [5:0] S_LR   = 6'b000010;
  localparam logic [5:0] S_BUMP = 6'b000100;
  localparam logic [5:0] S_BL   = 6'b001000;
  localparam logic [5:0] S_BM   = 6'b010000;
  localparam logic [5:0] S_BR   = 6'b100000;
  localparam logic [5:0] S_NONE = 6'b000000;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [87:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_pcts[3] = '{8, 70, 0};
  int recv_pcts[3] = '{70, 8, 0};

  drive_word_t pending_drive_words[$];
  drive_word_t mon_got;
  drive_word_t mon_want;

  // mirror of the controller state
  cfg_t              robot_cfg;
  mode_t             robot_mode;
  logic [3:0]        impacts;
  logic              waiting;
  logic [16:0]       hold_left;
  logic [1:0]        wave_step;
  logic signed [8:0] drv_p1, drv_p9, drv_p2, drv_p10;
  logic [23:0]       led_a, led_b;

  robot_mode_drive_controller i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic void reset_robot();
    robot_cfg.cruise_speed      = 8'd102;
    robot_cfg.sharp_turn_speed  = 8'd127;
    robot_cfg.mid_turn_speed    = 8'd76;
    robot_cfg.slow_turn_speed   = 8'd25;
    robot_cfg.impacts_to_switch = 4'd3;
    robot_cfg.bump_hold_ticks   = 16'd400;
    robot_cfg.result_hold_ticks = 16'd2000;
    robot_mode = MODE_LINE;
    impacts    = '0;
    waiting    = 1'b0;
    hold_left  = '0;
    wave_step  = WAVE_IDLE;
    drv_p1     = '0;
    drv_p9     = '0;
    drv_p2     = '0;
    drv_p10    = '0;
    led_a      = COL_START_A;
    led_b      = COL_START_B;
  endfunction

  function automatic void set_drives(input logic signed [8:0] a, b, c, d);
    drv_p1  = a;
    drv_p9  = b;
    drv_p2  = c;
    drv_p10 = d;
  endfunction

  function automatic void set_leds(input logic [23:0] a, b);
    led_a = a;
    led_b = b;
  endfunction

  function automatic drive_word_t advance_robot(input logic [5:0] sense);
    logic ll, lr, bump, bl, bm, br, good, bad, held;
    logic signed [8:0] cr, sh, md, sl;
    drive_word_t r;
    ll   = sense[0];
    lr   = sense[1];
    bump = sense[2];
    bl   = sense[3];
    bm   = sense[4];
    br   = sense[5];
    cr   = $signed({1'b0, robot_cfg.cruise_speed});
    sh   = $signed({1'b0, robot_cfg.sharp_turn_speed});
    md   = $signed({1'b0, robot_cfg.mid_turn_speed});
    sl   = $signed({1'b0, robot_cfg.slow_turn_speed});
    held = 1'b0;
    good = 1'b0;
    bad  = 1'b0;
    if (hold_left != 0) begin
      hold_left--;
      held = 1'b1;
    end else if (waiting) begin
      held = 1'b1;
      if (!bump) begin
        waiting = 1'b0;
        if (impacts >= robot_cfg.impacts_to_switch) begin
          robot_mode = MODE_OBST;
          set_leds(COL_START_A, COL_START_B);
        end
        hold_left = {1'b0, robot_cfg.bump_hold_ticks};
      end
    end else begin
      case (robot_mode)
        MODE_LINE: begin
          if (ll && lr) begin
            set_drives(cr, cr, -cr, -cr);
            set_leds(COL_GREEN, COL_GREEN);
          end else if (!ll && lr) begin
            set_drives(-sl, -sl, -sh, -sh);
            led_b = COL_BLUE;
          end else if (ll && !lr) begin
            set_drives(sh, sh, sl, sl);
            led_a = COL_BLUE;
          end else begin
            set_drives('0, '0, '0, '0);
            set_leds(COL_RED, COL_RED);
          end
          if (bump) begin
            if (impacts != 4'd15) impacts++;
            waiting = 1'b1;
          end
        end
        MODE_OBST: begin
          if (!bl && !bm && !br) begin
            set_drives(cr, cr, -cr, -cr);
            set_leds(COL_GREEN, COL_GREEN);
          end else if (bl && !br) begin
            set_drives(-sl, -sl, -md, -md);
            led_b = COL_BLUE;
          end else if (!bl && br) begin
            set_drives(md, md, sl, sl);
            led_a = COL_BLUE;
          end else if (!bl && bm && !br) begin
            set_drives('0, '0, '0, '0);
            set_leds(COL_RED, COL_RED);
            robot_mode = MODE_WAVE;
          end
        end
        MODE_WAVE: begin
          if (bl) wave_step = WAVE_LEFT;
          if (bm) begin
            if (wave_step == WAVE_IDLE) bad = 1'b1;
            if (wave_step == WAVE_LEFT) wave_step = WAVE_MID;
          end
          if (br && wave_step == WAVE_MID) good = 1'b1;
          if (good) begin
            set_leds(COL_GREEN, COL_GREEN);
            hold_left  = {1'b0, robot_cfg.result_hold_ticks};
            wave_step  = WAVE_IDLE;
            robot_mode = MODE_LINE;
          end else if (bad) begin
            set_leds(COL_RED, COL_RED);
            hold_left = {1'b0, robot_cfg.result_hold_ticks};
            wave_step = WAVE_IDLE;
          end
        end
        default: ;
      endcase
    end
    r.p1      = drv_p1;
    r.p9      = drv_p9;
    r.p2      = drv_p2;
    r.p10     = drv_p10;
    r.led_a   = led_a;
    r.led_b   = led_b;
    r.mode    = robot_mode;
    r.holding = held;
    return r;
  endfunction

  // random sensor word, steered toward bumps, the stop pattern and full waves
  function automatic logic [5:0] next_sample();
    logic [5:0] s;
    s = 6'($urandom_range(63));
    if (hold_left == 0 && !waiting) begin
      case (robot_mode)
        MODE_LINE: s[2] = ($urandom_range(5) == 0);
        MODE_OBST: if ($urandom_range(4) == 0) s[5:3] = 3'b010;
        MODE_WAVE: begin
          if ($urandom_range(9) < 7) begin
            case (wave_step)
              WAVE_IDLE: s[5:3] = 3'b001;
              WAVE_LEFT: s[5:3] = 3'b010;
              default:   s[5:3] = 3'b100;
            endcase
          end
        end
        default: ;
      endcase
    end
    return s;
  endfunction

  function automatic drive_word_t res(input int p1, p9, p2, p10, input logic [23:0] a, b,
                                      input mode_t m, input logic h);
    drive_word_t r;
    r.p1      = 9'(p1);
    r.p9      = 9'(p9);
    r.p2      = 9'(p2);
    r.p10     = 9'(p10);
    r.led_a   = a;
    r.led_b   = b;
    r.mode    = m;
    r.holding = h;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [2:0] sel, input logic [15:0] value);
    plan_row_t row;
    row = '{is_write: 1'b1, sel: sel, value: value, sense: '0, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t tick_row(input logic [5:0] sense);
    plan_row_t row;
    row = '{is_write: 1'b0, sel: '0, value: '0, sense: sense, typed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [5:0] sense, input drive_word_t want);
    plan_row_t row;
    row = '{is_write: 1'b0, sel: '0, value: '0, sense: sense, typed: 1'b1, want: want};
    return row;
  endfunction

  function automatic logic [7:0] pick_speed();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [15:0] pick_hold();
    case ($urandom_range(7))
      0:       return 16'd0;
      7:       return 16'($urandom_range(40, 8));
      default: return 16'($urandom_range(3, 1));
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want, got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic send_sample(input logic [5:0] sense, input bit typed, input drive_word_t want);
    drive_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, sense};
    do @(posedge clk); while (!s_axis_tready);
    pred = advance_robot(sense);
    pending_drive_words.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_drive_words.size() != 0);
  endtask

  task automatic write_reg(input logic [2:0] sel, input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (sel)
      REG_CRUISE:     robot_cfg.cruise_speed      = value[7:0];
      REG_SHARP_TURN: robot_cfg.sharp_turn_speed  = value[7:0];
      REG_MID_TURN:   robot_cfg.mid_turn_speed    = value[7:0];
      REG_SLOW_TURN:  robot_cfg.slow_turn_speed   = value[7:0];
      REG_IMPACTS:    robot_cfg.impacts_to_switch = value[3:0];
      REG_BUMP_HOLD:  robot_cfg.bump_hold_ticks   = value;
      REG_RES_HOLD:   robot_cfg.result_hold_ticks = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [7:0] cr, sh, md, sl, input logic [3:0] imp,
                           input logic [15:0] bh, rh);
    drain_results();
    write_reg(REG_CRUISE, {8'd0, cr});
    write_reg(REG_SHARP_TURN, {8'd0, sh});
    write_reg(REG_MID_TURN, {8'd0, md});
    write_reg(REG_SLOW_TURN, {8'd0, sl});
    write_reg(REG_IMPACTS, {12'd0, imp});
    write_reg(REG_BUMP_HOLD, bh);
    write_reg(REG_RES_HOLD, rh);
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got = drive_word_t'(m_axis_tdata[86:0]);
      if (pending_drive_words.size() == 0) begin
        $error("result word with no expectation pending");
        errors++;
      end else begin
        mon_want = pending_drive_words.pop_front();
        check_field("drive_port1", 32'(mon_want.p1), 32'(mon_got.p1));
        check_field("drive_port9", 32'(mon_want.p9), 32'(mon_got.p9));
        check_field("drive_port2", 32'(mon_want.p2), 32'(mon_got.p2));
        check_field("drive_port10", 32'(mon_want.p10), 32'(mon_got.p10));
        check_field("led_a_rgb", 32'(mon_want.led_a), 32'(mon_got.led_a));
        check_field("led_b_rgb", 32'(mon_want.led_b), 32'(mon_got.led_b));
        check_field("current_mode", 32'(mon_want.mode), 32'(mon_got.mode));
        check_field("holding", 32'(mon_want.holding), 32'(mon_got.holding));
      end
    end
  end

  initial begin
    #30ms;
    $display("robot_mode_drive_controller regression: fail");
    $finish;
  end

  initial begin
    plan_row_t plan[$];
    bit        long_seen;
    int        spins;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    reset_robot();
    send_idle_pct = send_pcts[0];
    recv_idle_pct = recv_pcts[0];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // line turns under reset settings
    plan.push_back(known_row(S_LL | S_LR,
                             res(102, 102, -102, -102, COL_GREEN, COL_GREEN, MODE_LINE, 1'b0)));
    plan.push_back(known_row(S_LL, res(127, 127, 25, 25, COL_BLUE, COL_GREEN, MODE_LINE, 1'b0)));
    plan.push_back(known_row(S_LR,
                             res(-25, -25, -127, -127, COL_BLUE, COL_BLUE, MODE_LINE, 1'b0)));
    plan.push_back(known_row(S_NONE, res(0, 0, 0, 0, COL_RED, COL_RED, MODE_LINE, 1'b0)));
    // extreme speeds, zero threshold, short holds
    plan.push_back(reg_row(REG_CRUISE, 16'd255));
    plan.push_back(reg_row(REG_SHARP_TURN, 16'd0));
    plan.push_back(reg_row(REG_MID_TURN, 16'd255));
    plan.push_back(reg_row(REG_SLOW_TURN, 16'd255));
    plan.push_back(reg_row(REG_IMPACTS, 16'd0));
    plan.push_back(reg_row(REG_BUMP_HOLD, 16'd2));
    plan.push_back(reg_row(REG_RES_HOLD, 16'd1));
    plan.push_back(known_row(S_LL | S_LR | S_BUMP,
                             res(255, 255, -255, -255, COL_GREEN, COL_GREEN, MODE_LINE, 1'b0)));
    plan.push_back(tick_row(S_BUMP | S_BL));
    plan.push_back(tick_row(S_BR));
    plan.push_back(tick_row(S_LL));
    plan.push_back(tick_row(S_LR));
    // obstacle branches in priority order
    plan.push_back(tick_row(S_NONE));
    plan.push_back(tick_row(S_BL));
    plan.push_back(tick_row(S_BL | S_BM));
    plan.push_back(tick_row(S_BR));
    plan.push_back(tick_row(S_BM | S_BR));
    plan.push_back(tick_row(S_BL | S_BR));
    plan.push_back(tick_row(S_BL | S_BM | S_BR));
    plan.push_back(tick_row(S_BM));
    // wave: middle first, then left middle right
    plan.push_back(tick_row(S_BM));
    plan.push_back(tick_row(S_NONE));
    plan.push_back(tick_row(S_BL));
    plan.push_back(tick_row(S_BM));
    plan.push_back(tick_row(S_BR | S_BUMP));
    plan.push_back(tick_row(S_NONE));
    // count kept after wave, next press switches at once
    plan.push_back(tick_row(S_LL | S_BUMP));
    plan.push_back(tick_row(S_NONE));

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        drain_results();
        write_reg(plan[i].sel, plan[i].value);
      end else begin
        send_sample(plan[i].sense, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pcts[ph];
      recv_idle_pct = recv_pcts[ph];
      for (int seg = 0; seg < 2; seg++) begin
        write_all(pick_speed(), pick_speed(), pick_speed(), pick_speed(),
                  ($urandom_range(3) == 0) ? 4'd15 : 4'($urandom_range(6, 1)),
                  pick_hold(), pick_hold());
        for (int n = 0; n < 104; n++) begin
          if ($urandom_range(99) == 0) drain_results();
          send_sample(next_sample(), 1'b0, '0);
        end
      end
    end

    // moderate holds, run until one has fully expired
    write_all(pick_speed(), pick_speed(), pick_speed(), pick_speed(), 4'd1,
              16'd12, 16'd12);
    long_seen = 1'b0;
    spins = 0;
    while (!(long_seen && hold_left == 0 && !waiting) && spins < 400) begin
      send_sample(next_sample(), 1'b0, '0);
      if (hold_left == 17'd12) long_seen = 1'b1;
      spins++;
    end
    for (int n = 0; n < 12; n++) send_sample(next_sample(), 1'b0, '0);

    drain_results();
    repeat (4) @(posedge clk);
    if (errors == 0 && pending_drive_words.size() == 0) begin
      $display("robot_mode_drive_controller regression: pass");
    end else begin
      $display("robot_mode_drive_controller regression: fail");
    end
    $finish;
  end

endmodule
